// ===== src/upqv_pkg.sv =====
// ----------------------------------------------------------------------------
// upqv_pkg
// Shared types, character codes and helpers for the URL path/query validator.
// ----------------------------------------------------------------------------
package upqv_pkg;

   typedef logic [7:0] byte_type;

   typedef enum logic [2:0] {
      ROLE_LEAD_SLASH = 3'd0,
      ROLE_PATH_CHAR  = 3'd1,
      ROLE_PATH_SEP   = 3'd2,
      ROLE_QUERY_MARK = 3'd3,
      ROLE_KEY_CHAR   = 3'd4,
      ROLE_EQUALS     = 3'd5,
      ROLE_VALUE_CHAR = 3'd6,
      ROLE_PARAM_SEP  = 3'd7
   } role_type;

   typedef enum logic [1:0] {
      PHASE_LEAD  = 2'd0,
      PHASE_PATH  = 2'd1,
      PHASE_KEY   = 2'd2,
      PHASE_VALUE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      DOT_NONE  = 2'd0,
      DOT_ONE   = 2'd1,
      DOT_TWO   = 2'd2,
      DOT_OTHER = 2'd3
   } dot_kind_type;

   localparam byte_type CHAR_SLASH      = 8'h2F;
   localparam byte_type CHAR_QUESTION   = 8'h3F;
   localparam byte_type CHAR_AMPERSAND  = 8'h26;
   localparam byte_type CHAR_EQUALS     = 8'h3D;
   localparam byte_type CHAR_UNDERSCORE = 8'h5F;
   localparam byte_type CHAR_DOT        = 8'h2E;

   function automatic logic ident_char(input byte_type c);
      ident_char = (c >= 8'h30 && c <= 8'h39) ||
                   (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h41 && c <= 8'h5A) ||
                   (c == CHAR_UNDERSCORE);
   endfunction

endpackage

// ===== src/upqv_req_if.sv =====
// ----------------------------------------------------------------------------
// upqv_req_if
// Request channel: one URL byte per request with a last marker.
// ----------------------------------------------------------------------------
interface upqv_req_if;
   logic                valid;
   logic                ready;
   upqv_pkg::byte_type  url_byte;
   logic                is_last;

   modport source (output valid, output url_byte, output is_last, input ready);
   modport sink   (input valid, input url_byte, input is_last, output ready);
endinterface

// ===== src/upqv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// upqv_rsp_if
// Result channel: byte role, sticky fail and acceptance on the last byte.
// ----------------------------------------------------------------------------
interface upqv_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] role;
   logic       fail;
   logic       accept;

   modport source (output valid, output role, output fail, output accept, input ready);
   modport sink   (input valid, input role, input fail, input accept, output ready);
endinterface

// ===== src/url_path_query_validator.sv =====
// ----------------------------------------------------------------------------
// url_path_query_validator
// The result is registered and becomes valid in the cycle after request acceptance.
// Throughput: 1 request per cycle; the output register is refilled in the
// cycle it drains, so back-pressure only stalls when the result is held.
// Reset: synchronous, clears the parser state and the output valid flag.
// Streaming URL byte classifier with sticky failure and end-of-URL verdict.
// ----------------------------------------------------------------------------
module url_path_query_validator (
   input  logic        clock,
   input  logic        reset,
   upqv_req_if.sink    req_chan,
   upqv_rsp_if.source  rsp_chan
);

   upqv_pkg::phase_type    phase_ff, phase_in;
   upqv_pkg::dot_kind_type dot_kind_ff, dot_kind_in;
   logic                   seg_nonempty_ff, seg_nonempty_in;
   logic                   failed_ff, failed_in;

   upqv_pkg::role_type     role_in;
   upqv_pkg::role_type     rsp_role_ff;
   logic                   rsp_fail_ff, rsp_accept_ff, rsp_valid_ff;
   logic                   bad;
   logic                   req_fire;
   upqv_pkg::byte_type     c;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign c              = req_chan.url_byte;

   always_comb begin
      phase_in        = phase_ff;
      dot_kind_in     = dot_kind_ff;
      seg_nonempty_in = seg_nonempty_ff;
      role_in         = upqv_pkg::ROLE_LEAD_SLASH;
      bad             = 1'b0;
      case (phase_ff)
         upqv_pkg::PHASE_LEAD: begin
            role_in         = upqv_pkg::ROLE_LEAD_SLASH;
            bad             = (c != upqv_pkg::CHAR_SLASH);
            phase_in        = upqv_pkg::PHASE_PATH;
            seg_nonempty_in = 1'b0;
            dot_kind_in     = upqv_pkg::DOT_NONE;
         end
         upqv_pkg::PHASE_PATH: begin
            if (c == upqv_pkg::CHAR_SLASH) begin
               role_in = upqv_pkg::ROLE_PATH_SEP;
               bad     = !seg_nonempty_ff || dot_kind_ff == upqv_pkg::DOT_ONE ||
                         dot_kind_ff == upqv_pkg::DOT_TWO;
               seg_nonempty_in = 1'b0;
               dot_kind_in     = upqv_pkg::DOT_NONE;
            end else if (c == upqv_pkg::CHAR_QUESTION) begin
               role_in = upqv_pkg::ROLE_QUERY_MARK;
               bad     = dot_kind_ff == upqv_pkg::DOT_ONE ||
                         dot_kind_ff == upqv_pkg::DOT_TWO;
               phase_in        = upqv_pkg::PHASE_KEY;
               seg_nonempty_in = 1'b0;
               dot_kind_in     = upqv_pkg::DOT_NONE;
            end else begin
               role_in = upqv_pkg::ROLE_PATH_CHAR;
               if (c == upqv_pkg::CHAR_DOT) begin
                  case (dot_kind_ff)
                     upqv_pkg::DOT_NONE: dot_kind_in = upqv_pkg::DOT_ONE;
                     upqv_pkg::DOT_ONE:  dot_kind_in = upqv_pkg::DOT_TWO;
                     default:            dot_kind_in = upqv_pkg::DOT_OTHER;
                  endcase
               end else begin
                  dot_kind_in = upqv_pkg::DOT_OTHER;
                  bad         = !upqv_pkg::ident_char(c);
               end
               seg_nonempty_in = 1'b1;
            end
         end
         upqv_pkg::PHASE_KEY: begin
            if (c == upqv_pkg::CHAR_AMPERSAND) begin
               role_in         = upqv_pkg::ROLE_PARAM_SEP;
               bad             = 1'b1;
               seg_nonempty_in = 1'b0;
            end else if (c == upqv_pkg::CHAR_EQUALS) begin
               role_in         = upqv_pkg::ROLE_EQUALS;
               bad             = !seg_nonempty_ff;
               phase_in        = upqv_pkg::PHASE_VALUE;
               seg_nonempty_in = 1'b0;
            end else begin
               role_in         = upqv_pkg::ROLE_KEY_CHAR;
               bad             = !upqv_pkg::ident_char(c);
               seg_nonempty_in = 1'b1;
            end
         end
         default: begin
            if (c == upqv_pkg::CHAR_AMPERSAND) begin
               role_in         = upqv_pkg::ROLE_PARAM_SEP;
               bad             = !seg_nonempty_ff;
               phase_in        = upqv_pkg::PHASE_KEY;
               seg_nonempty_in = 1'b0;
            end else begin
               role_in         = upqv_pkg::ROLE_VALUE_CHAR;
               bad             = !upqv_pkg::ident_char(c);
               seg_nonempty_in = 1'b1;
            end
         end
      endcase

      // end-of-URL checks on the post-byte state
      if (req_chan.is_last) begin
         if (phase_in == upqv_pkg::PHASE_PATH &&
             (dot_kind_in == upqv_pkg::DOT_ONE || dot_kind_in == upqv_pkg::DOT_TWO)) begin
            bad = 1'b1;
         end
         if (phase_in == upqv_pkg::PHASE_KEY && seg_nonempty_in) begin
            bad = 1'b1;
         end
         if (phase_in == upqv_pkg::PHASE_VALUE && !seg_nonempty_in) begin
            bad = 1'b1;
         end
      end
      failed_in = failed_ff || bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= upqv_pkg::PHASE_LEAD;
         dot_kind_ff     <= upqv_pkg::DOT_NONE;
         seg_nonempty_ff <= 1'b0;
         failed_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            if (req_chan.is_last) begin
               phase_ff        <= upqv_pkg::PHASE_LEAD;
               dot_kind_ff     <= upqv_pkg::DOT_NONE;
               seg_nonempty_ff <= 1'b0;
               failed_ff       <= 1'b0;
            end else begin
               phase_ff        <= phase_in;
               dot_kind_ff     <= dot_kind_in;
               seg_nonempty_ff <= seg_nonempty_in;
               failed_ff       <= failed_in;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_role_ff   <= role_in;
         rsp_fail_ff   <= failed_in;
         rsp_accept_ff <= req_chan.is_last && !failed_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.role   = rsp_role_ff;
   assign rsp_chan.fail   = rsp_fail_ff;
   assign rsp_chan.accept = rsp_accept_ff;

   a_accept_not_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_accept_ff |-> !rsp_fail_ff)
      else $error("accept reported together with fail");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.is_last |=>
         phase_ff == upqv_pkg::PHASE_LEAD && !failed_ff && !seg_nonempty_ff)
      else $error("parser state not cleared after last byte");

   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff && !(req_fire && req_chan.is_last) |=> failed_ff)
      else $error("sticky fail dropped within a URL");

   a_lead_role: assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == upqv_pkg::PHASE_LEAD |=>
         rsp_valid_ff && rsp_role_ff == upqv_pkg::ROLE_LEAD_SLASH)
      else $error("first byte not classified as leading slash");

   a_result_after_request: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no result");

endmodule

// ===== tb/tb_url_path_query_validator.sv =====
// ----------------------------------------------------------------------------
// tb_url_path_query_validator
// Self-checking bench for the streaming URL path/query validator. A short
// directed set of URLs hits each grammar corner. Then random URLs follow:
// mostly well formed, some corrupted, some pure noise. Both handshake sides
// idle at random, and the receiver holds off for long stretches so the
// request side stalls. Every result is checked against an in-bench grammar
// tracker for role, fail and accept.
// ----------------------------------------------------------------------------
module tb_url_path_query_validator;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      upqv_pkg::role_type role;
      logic               fail;
      logic               accept;
   } url_verdict_type;

   class url_scoreboard;
      upqv_pkg::phase_type    phase;
      logic                   seg_nonempty;
      upqv_pkg::dot_kind_type dot_kind;
      logic                   failed;
      url_verdict_type        pending_verdicts[$];
      int unsigned            mismatches;
      int unsigned            verdicts_checked;
      int unsigned            urls_seen;
      int unsigned            urls_accepted;

      function new();
         clear_url();
         mismatches = 0;
         verdicts_checked = 0;
         urls_seen = 0;
         urls_accepted = 0;
      endfunction

      function void clear_url();
         phase = upqv_pkg::PHASE_LEAD;
         seg_nonempty = 1'b0;
         dot_kind = upqv_pkg::DOT_NONE;
         failed = 1'b0;
      endfunction

      function logic word_char(upqv_pkg::byte_type c);
         return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                (c >= "A" && c <= "Z") || c == upqv_pkg::CHAR_UNDERSCORE;
      endfunction

      // Advance the grammar by one accepted request and queue its verdict.
      function void take_request(upqv_pkg::byte_type c, logic last);
         url_verdict_type v;
         logic bad;
         bad = 1'b0;
         case (phase)
            upqv_pkg::PHASE_LEAD: begin
               v.role = upqv_pkg::ROLE_LEAD_SLASH;
               bad = (c != upqv_pkg::CHAR_SLASH);
               phase = upqv_pkg::PHASE_PATH;
               seg_nonempty = 1'b0;
               dot_kind = upqv_pkg::DOT_NONE;
            end
            upqv_pkg::PHASE_PATH: begin
               if (c == upqv_pkg::CHAR_SLASH) begin
                  v.role = upqv_pkg::ROLE_PATH_SEP;
                  bad = !seg_nonempty || dot_kind == upqv_pkg::DOT_ONE ||
                        dot_kind == upqv_pkg::DOT_TWO;
                  seg_nonempty = 1'b0;
                  dot_kind = upqv_pkg::DOT_NONE;
               end else if (c == upqv_pkg::CHAR_QUESTION) begin
                  v.role = upqv_pkg::ROLE_QUERY_MARK;
                  bad = (dot_kind == upqv_pkg::DOT_ONE || dot_kind == upqv_pkg::DOT_TWO);
                  phase = upqv_pkg::PHASE_KEY;
                  seg_nonempty = 1'b0;
                  dot_kind = upqv_pkg::DOT_NONE;
               end else begin
                  v.role = upqv_pkg::ROLE_PATH_CHAR;
                  if (c == upqv_pkg::CHAR_DOT) begin
                     if (dot_kind != upqv_pkg::DOT_OTHER)
                        dot_kind = upqv_pkg::dot_kind_type'(dot_kind + 2'd1);
                  end else begin
                     dot_kind = upqv_pkg::DOT_OTHER;
                     bad = !word_char(c);
                  end
                  seg_nonempty = 1'b1;
               end
            end
            upqv_pkg::PHASE_KEY: begin
               if (c == upqv_pkg::CHAR_AMPERSAND) begin
                  v.role = upqv_pkg::ROLE_PARAM_SEP;
                  bad = 1'b1;
                  seg_nonempty = 1'b0;
               end else if (c == upqv_pkg::CHAR_EQUALS) begin
                  v.role = upqv_pkg::ROLE_EQUALS;
                  bad = !seg_nonempty;
                  phase = upqv_pkg::PHASE_VALUE;
                  seg_nonempty = 1'b0;
               end else begin
                  v.role = upqv_pkg::ROLE_KEY_CHAR;
                  bad = !word_char(c);
                  seg_nonempty = 1'b1;
               end
            end
            default: begin
               if (c == upqv_pkg::CHAR_AMPERSAND) begin
                  v.role = upqv_pkg::ROLE_PARAM_SEP;
                  bad = !seg_nonempty;
                  phase = upqv_pkg::PHASE_KEY;
                  seg_nonempty = 1'b0;
               end else begin
                  v.role = upqv_pkg::ROLE_VALUE_CHAR;
                  bad = !word_char(c);
                  seg_nonempty = 1'b1;
               end
            end
         endcase
         if (last) begin
            if (phase == upqv_pkg::PHASE_PATH &&
                (dot_kind == upqv_pkg::DOT_ONE || dot_kind == upqv_pkg::DOT_TWO))
               bad = 1'b1;
            if (phase == upqv_pkg::PHASE_KEY && seg_nonempty) bad = 1'b1;
            if (phase == upqv_pkg::PHASE_VALUE && !seg_nonempty) bad = 1'b1;
         end
         if (bad) failed = 1'b1;
         v.fail = failed;
         v.accept = last && !failed;
         pending_verdicts.insert(pending_verdicts.size(), v);
         if (last) clear_url();
      endfunction

      function void check_verdict(logic [2:0] role, logic fail, logic accept);
         url_verdict_type v;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result role=%0d fail=%b accept=%b",
                        $realtime, role, fail, accept);
            return;
         end
         v = pending_verdicts.pop_front();
         verdicts_checked++;
         if (v.accept) urls_accepted++;
         if (role !== v.role || fail !== v.fail || accept !== v.accept) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: result %0d expected role=%0d fail=%b accept=%b,",
                         " got role=%0d fail=%b accept=%b"},
                        $realtime, verdicts_checked, v.role, v.fail, v.accept,
                        role, fail, accept);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   upqv_req_if req_chan ();
   upqv_rsp_if rsp_chan ();

   url_path_query_validator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   url_scoreboard      sb;
   upqv_pkg::byte_type url_buf[$];
   logic               send_calm;
   logic               recv_calm;
   int unsigned        bytes_sent;
   int unsigned        long_holds;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("url_path_query_validator verification failed");
      $finish;
   end

   function automatic void add_byte(upqv_pkg::byte_type b);
      url_buf.insert(url_buf.size(), b);
   endfunction

   function automatic void load_url(string s);
      url_buf.delete();
      for (int i = 0; i < s.len(); i++) add_byte(upqv_pkg::byte_type'(s[i]));
   endfunction

   function automatic void add_word();
      int unsigned n;
      int unsigned k;
      n = $urandom_range(1, 4);
      repeat (n) begin
         k = $urandom_range(0, 62);
         if (k < 10) add_byte(upqv_pkg::byte_type'("0" + k));
         else if (k < 36) add_byte(upqv_pkg::byte_type'("a" + k - 10));
         else if (k < 62) add_byte(upqv_pkg::byte_type'("A" + k - 36));
         else add_byte(upqv_pkg::CHAR_UNDERSCORE);
      end
   endfunction

   function automatic void add_segment();
      case ($urandom_range(0, 9))
         0: add_byte(upqv_pkg::CHAR_DOT);
         1: begin add_byte(upqv_pkg::CHAR_DOT); add_byte(upqv_pkg::CHAR_DOT); end
         2: repeat (3) add_byte(upqv_pkg::CHAR_DOT);
         3: begin add_word(); add_byte(upqv_pkg::CHAR_DOT); add_word(); end
         default: add_word();
      endcase
   endfunction

   function automatic void build_url();
      upqv_pkg::byte_type specials[5];
      int unsigned        nseg;
      int unsigned        npar;
      int unsigned        pos;
      specials = '{upqv_pkg::CHAR_SLASH, upqv_pkg::CHAR_QUESTION, upqv_pkg::CHAR_AMPERSAND,
                   upqv_pkg::CHAR_EQUALS, upqv_pkg::CHAR_DOT};
      url_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) add_byte(upqv_pkg::byte_type'($urandom_range(0, 255)));
         return;
      end
      add_byte(upqv_pkg::CHAR_SLASH);
      nseg = $urandom_range(0, 3);
      for (int i = 0; i < nseg; i++) begin
         if (i > 0) add_byte(upqv_pkg::CHAR_SLASH);
         add_segment();
      end
      if (nseg > 0 && $urandom_range(0, 3) == 0) add_byte(upqv_pkg::CHAR_SLASH);
      if ($urandom_range(0, 1) == 1) begin
         add_byte(upqv_pkg::CHAR_QUESTION);
         npar = $urandom_range(0, 3);
         for (int j = 0; j < npar; j++) begin
            if (j > 0) add_byte(upqv_pkg::CHAR_AMPERSAND);
            add_word();
            add_byte(upqv_pkg::CHAR_EQUALS);
            add_word();
         end
         if (npar > 0 && $urandom_range(0, 3) == 0) add_byte(upqv_pkg::CHAR_AMPERSAND);
      end
      if ($urandom_range(0, 3) == 0) begin
         pos = $urandom_range(0, url_buf.size() - 1);
         case ($urandom_range(0, 2))
            0: url_buf[pos] = upqv_pkg::byte_type'($urandom_range(0, 255));
            1: url_buf[pos] = specials[$urandom_range(0, 4)];
            default: if (url_buf.size() > 1) url_buf.delete(pos);
         endcase
      end
   endfunction

   task automatic send_url();
      int unsigned gap;
      logic        last;
      send_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < url_buf.size(); i++) begin
         gap = send_calm ? 0 : $urandom_range(0, 5);
         last = (i == url_buf.size() - 1);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_chan.valid    <= 1'b1;
         req_chan.url_byte <= url_buf[i];
         req_chan.is_last  <= last;
         do @(posedge clock); while (!req_chan.ready);
         sb.take_request(url_buf[i], last);
         bytes_sent++;
      end
      sb.urls_seen++;
   endtask

   task automatic receive_results();
      int unsigned gap;
      int unsigned taken;
      taken = 0;
      recv_calm = 1'b0;
      rsp_chan.ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!rsp_chan.valid);
         sb.check_verdict(rsp_chan.role, rsp_chan.fail, rsp_chan.accept);
         taken++;
         if (taken % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
         if (taken == 150 || taken == 400) begin
            gap = 64;
            long_holds++;
         end else begin
            gap = recv_calm ? 0 : $urandom_range(0, 5);
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   endtask

   initial begin
      int unsigned drain;
      sb = new();
      bytes_sent = 0;
      long_holds = 0;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.url_byte <= '0;
      req_chan.is_last  <= 1'b0;
      rsp_chan.ready    <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      fork
         receive_results();
      join_none

      // directed corners
      load_url("/");       send_url();
      url_buf = '{8'hFF};  send_url();
      load_url("//");      send_url();
      load_url("/./");     send_url();
      load_url("/..?");    send_url();
      load_url("/.");      send_url();
      load_url("/?&");     send_url();
      load_url("/?a=b&");  send_url();
      load_url("/??");     send_url();
      load_url("/?a==");   send_url();
      load_url("/?k");     send_url();
      load_url("/?k=");    send_url();

      while (bytes_sent < 500) begin
         build_url();
         send_url();
      end
      req_chan.valid <= 1'b0;

      drain = 0;
      while (sb.pending_verdicts.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (4) @(posedge clock);
      if (sb.pending_verdicts.size() != 0) begin
         $display("%0d expected results never arrived", sb.pending_verdicts.size());
         sb.mismatches++;
      end

      $display("covered %0d URLs in %0d bytes: %0d accepted, %0d rejected",
               sb.urls_seen, bytes_sent, sb.urls_accepted, sb.urls_seen - sb.urls_accepted);
      $display("receiver held off %0d times for long stretches; %0d mismatches",
               long_holds, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("url_path_query_validator verification clean");
      end else begin
         $display("url_path_query_validator verification failed");
      end
      $finish;
   end

endmodule
